FILE: src/apf_pkg.sv
// ---------------------------------------------------------------------------
// apf_pkg - ancillary packet formatter shared types
// Request and response payload types, the word burst passed from the
// formatter to the output buffer, and the word coding helpers.
// ---------------------------------------------------------------------------
`default_nettype none

package apf_pkg;

   localparam int MAX_WORDS = 8;
   localparam int COUNT_W   = 4;
   localparam int IDX_W     = 3;

   localparam logic [4:0] DEPTH_OK  = 5'd10;
   localparam logic [9:0] ADF_ZERO  = 10'h000;
   localparam logic [9:0] ADF_ONES  = 10'h3ff;

   // burst lengths
   localparam logic [COUNT_W-1:0] CNT_ERROR     = 4'd1;
   localparam logic [COUNT_W-1:0] CNT_DATA      = 4'd1;
   localparam logic [COUNT_W-1:0] CNT_DATA_END  = 4'd2;
   localparam logic [COUNT_W-1:0] CNT_START     = 4'd7;
   localparam logic [COUNT_W-1:0] CNT_START_END = 4'd8;

   typedef struct packed {
      logic       start_req;
      logic [7:0] did_code;
      logic [7:0] sdid_code;
      logic [7:0] byte_count;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [9:0] word;
      logic       last_word;
      logic       error;
   } rsp_type;

   typedef struct packed {
      rsp_type [MAX_WORDS-1:0] words;
      logic [COUNT_W-1:0]      count;
   } burst_type;

   // 8-bit value with even parity in bit 8 and its inverse in bit 9
   function automatic logic [9:0] code_byte(input logic [7:0] v);
      logic p;
      p = ^v;
      return {~p, p, v};
   endfunction

   // checksum word: 9-bit sum with inverse of bit 8 in bit 9
   function automatic logic [9:0] checksum_word(input logic [8:0] s);
      return {~s[8], s};
   endfunction

endpackage

`default_nettype wire

FILE: src/anc_packet_formatter_unit.sv
// ---------------------------------------------------------------------------
// anc_packet_formatter_unit - 10-bit ancillary packet formatter
// Builds ancillary packets (flag, DID, SDID, DC, data, checksum) from
// start and data requests.
// ---------------------------------------------------------------------------
`default_nettype none

// A request passes an input register, then the formatter turns it into a
// burst of one to eight packet words in a single cycle, which the output
// buffer hands out one word per accepted response. A one-word data request
// is taken every cycle while rsp_ready is high; a request of n words holds
// the single response port until all n are taken (7 or 8 for a start, 2
// for the last data byte), so the sustained rate is one response word per
// cycle while rsp_ready is high. Rejected starts (bad word depth, zero DID,
// SDID or count) and data with no open packet yield one word 0 with
// last_word and error set. word_depth is written through csr_wr_en /
// csr_wr_data; the user must do so only while the block is idle (unenforced).

module anc_packet_formatter_unit
   import apf_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   // configuration
   input  wire logic       csr_wr_en,
   input  wire logic [4:0] csr_wr_data,
   // request channel
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire req_type    req_payload,
   // response channel
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output rsp_type         rsp_payload
);

   logic [4:0] word_depth_ff;
   logic       in_valid_ff;
   req_type    in_item_ff;

   burst_type  burst;
   logic       fire;        // input register hands its request to the formatter
   logic       load_ok;     // buffer free now or freeing this cycle
   logic       fmt_active;
   logic [IDX_W-1:0] burst_last_idx;
   logic       burst_ends;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         word_depth_ff <= DEPTH_OK;
      end else if (csr_wr_en) begin
         word_depth_ff <= csr_wr_data;
      end
   end

   // input register: refilled in the same cycle it drains
   assign fire      = in_valid_ff && load_ok;
   assign req_ready = !in_valid_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         in_valid_ff <= 1'b1;
      end else if (fire) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= req_payload;
      end
   end

   // burst generation and packet state
   apf_formatter u_formatter (
      .clock      (clock),
      .reset      (reset),
      .word_depth (word_depth_ff),
      .item       (in_item_ff),
      .fire       (fire),
      .burst      (burst),
      .active     (fmt_active)
   );

   // one word per response
   apf_burst_buffer u_buffer (
      .clock       (clock),
      .reset       (reset),
      .burst       (burst),
      .load        (fire),
      .load_ok     (load_ok),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   // final word of the burst being loaded
   assign burst_last_idx = IDX_W'(burst.count - 4'd1);
   assign burst_ends     = burst.words[burst_last_idx].last_word;

`ifndef SYNTH
   // every burst holds between one and eight words
   a_burst_count: assert property (@(posedge clock) disable iff (reset)
      fire |-> (burst.count != '0) && (burst.count <= CNT_START_END))
      else $error("burst length out of range");

   // a burst ending in a last word leaves no packet open
   a_closed_after_last: assert property (@(posedge clock) disable iff (reset)
      (fire && burst_ends) |=> !fmt_active)
      else $error("packet still open after last word");

   // error responses are a lone zero word that closes the burst
   a_error_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.error) |->
         (rsp_payload.last_word && (rsp_payload.word == ADF_ZERO)))
      else $error("malformed error response");
`endif

endmodule

`default_nettype wire

FILE: src/apf_formatter.sv
// ---------------------------------------------------------------------------
// apf_formatter - packet state and word burst generation
// Turns one request into its burst of packet words and keeps the
// open packet state (active, bytes left, running sum).
// ---------------------------------------------------------------------------
`default_nettype none

module apf_formatter
   import apf_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic [4:0] word_depth,
   input  wire req_type    item,
   input  wire logic       fire,
   output burst_type       burst,
   output logic            active
);

   logic       active_ff, active_in;
   logic [7:0] bytes_left_ff, bytes_left_in;
   logic [8:0] running_sum_ff, running_sum_in;

   logic [9:0] did_w, sdid_w, cnt_w, data_w;
   logic [8:0] sum_start, sum_data;
   logic [7:0] left_next;
   logic       reject;

   assign did_w  = code_byte(item.did_code);
   assign sdid_w = code_byte(item.sdid_code);
   assign cnt_w  = code_byte(item.byte_count);
   assign data_w = code_byte(item.data_byte);

   assign sum_start = did_w[8:0] + sdid_w[8:0] + cnt_w[8:0] + data_w[8:0];
   assign sum_data  = running_sum_ff + data_w[8:0];
   assign left_next = bytes_left_ff - 8'd1;

   assign reject = (word_depth != DEPTH_OK) || (item.did_code == 8'd0) ||
                   (item.sdid_code == 8'd0) || (item.byte_count == 8'd0);

   always_comb begin
      burst          = '0;
      active_in      = active_ff;
      bytes_left_in  = bytes_left_ff;
      running_sum_in = running_sum_ff;
      if (item.start_req) begin
         if (reject) begin
            burst.words[0] = '{word: ADF_ZERO, last_word: 1'b1, error: 1'b1};
            burst.count    = CNT_ERROR;
            active_in      = 1'b0;
            bytes_left_in  = 8'd0;
            running_sum_in = 9'd0;
         end else begin
            burst.words[0] = '{word: ADF_ZERO, last_word: 1'b0, error: 1'b0};
            burst.words[1] = '{word: ADF_ONES, last_word: 1'b0, error: 1'b0};
            burst.words[2] = '{word: ADF_ONES, last_word: 1'b0, error: 1'b0};
            burst.words[3] = '{word: did_w,    last_word: 1'b0, error: 1'b0};
            burst.words[4] = '{word: sdid_w,   last_word: 1'b0, error: 1'b0};
            burst.words[5] = '{word: cnt_w,    last_word: 1'b0, error: 1'b0};
            burst.words[6] = '{word: data_w,   last_word: 1'b0, error: 1'b0};
            if (item.byte_count == 8'd1) begin
               // single byte packet closes right away
               burst.words[7] = '{word: checksum_word(sum_start), last_word: 1'b1,
                                  error: 1'b0};
               burst.count    = CNT_START_END;
               active_in      = 1'b0;
               bytes_left_in  = 8'd0;
               running_sum_in = 9'd0;
            end else begin
               burst.count    = CNT_START;
               active_in      = 1'b1;
               bytes_left_in  = item.byte_count - 8'd1;
               running_sum_in = sum_start;
            end
         end
      end else if (!active_ff) begin
         // data while idle, state kept
         burst.words[0] = '{word: ADF_ZERO, last_word: 1'b1, error: 1'b1};
         burst.count    = CNT_ERROR;
      end else begin
         burst.words[0] = '{word: data_w, last_word: 1'b0, error: 1'b0};
         if (left_next == 8'd0) begin
            burst.words[1] = '{word: checksum_word(sum_data), last_word: 1'b1,
                               error: 1'b0};
            burst.count    = CNT_DATA_END;
            active_in      = 1'b0;
            bytes_left_in  = 8'd0;
            running_sum_in = 9'd0;
         end else begin
            burst.count    = CNT_DATA;
            bytes_left_in  = left_next;
            running_sum_in = sum_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff      <= 1'b0;
         bytes_left_ff  <= 8'd0;
         running_sum_ff <= 9'd0;
      end else if (fire) begin
         active_ff      <= active_in;
         bytes_left_ff  <= bytes_left_in;
         running_sum_ff <= running_sum_in;
      end
   end

   assign active = active_ff;

endmodule

`default_nettype wire

FILE: src/apf_burst_buffer.sv
// ---------------------------------------------------------------------------
// apf_burst_buffer - response word serializer
// Holds one burst of packet words and hands them out one per
// accepted response.
// ---------------------------------------------------------------------------
`default_nettype none

module apf_burst_buffer
   import apf_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire burst_type burst,
   input  wire logic      load,
   output logic           load_ok,
   output logic           rsp_valid,
   input  wire logic      rsp_ready,
   output rsp_type        rsp_payload
);

   rsp_type [MAX_WORDS-1:0] words_ff;
   logic [COUNT_W-1:0]      count_ff;
   logic [IDX_W-1:0]        idx_ff;
   logic                    taken, last_out;

   assign rsp_valid   = (count_ff != '0);
   assign rsp_payload = words_ff[idx_ff];
   assign taken       = rsp_valid && rsp_ready;
   assign last_out    = taken && ({1'b0, idx_ff} == (count_ff - 4'd1));
   assign load_ok     = !rsp_valid || last_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         idx_ff   <= '0;
      end else if (load) begin
         count_ff <= burst.count;
         idx_ff   <= '0;
      end else if (last_out) begin
         count_ff <= '0;
         idx_ff   <= '0;
      end else if (taken) begin
         idx_ff <= idx_ff + 3'd1;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (load) begin
         words_ff <= burst.words;
      end
   end

endmodule

`default_nettype wire

FILE: bench/anc_packet_word_checker.sv
// ---------------------------------------------------------------------------
// anc_packet_word_checker - ancillary packet word predictor and checker
// Watches the csr, request and response ports of the packet formatter,
// works out the packet words that each accepted request should produce
// and compares every accepted response word with the oldest one due.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module anc_packet_word_checker
   import apf_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_wr_en,
   input  wire logic [4:0] csr_wr_data,
   input  wire logic       req_valid,
   input  wire logic       req_ready,
   input  wire req_type    req_payload,
   input  wire logic       rsp_valid,
   input  wire logic       rsp_ready,
   input  wire rsp_type    rsp_payload,
   output int              mismatches,
   output int              words_due
);

   localparam logic [9:0] ERROR_WORD = 10'h000;

   // predictor state
   logic [4:0] depth_setting;
   logic       packet_open;
   logic [7:0] bytes_due;
   logic [8:0] word_sum;
   rsp_type    due_words[$];

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t ns: mismatch on %s, got 'h%0h, want 'h%0h", $realtime, what, got, want);
      mismatches++;
   endtask

   // even parity in bit 8, its inverse in bit 9
   function automatic logic [9:0] parity_coded(input logic [7:0] v);
      int ones;
      ones = 0;
      for (int i = 0; i < 8; i++)
         ones += v[i];
      return (ones % 2 == 1) ? {2'b01, v} : {2'b10, v};
   endfunction

   task automatic queue_word(input logic [9:0] w, input logic last, input logic err);
      rsp_type r;
      r.word      = w;
      r.last_word = last;
      r.error     = err;
      due_words.push_back(r);
   endtask

   task automatic queue_coded(input logic [7:0] v);
      logic [9:0] w;
      w        = parity_coded(v);
      word_sum = word_sum + w[8:0];
      queue_word(w, 1'b0, 1'b0);
   endtask

   // data word, then the checksum once the last byte is in
   task automatic queue_data(input logic [7:0] v);
      queue_coded(v);
      bytes_due = bytes_due - 8'd1;
      if (bytes_due == 8'd0) begin
         queue_word({~word_sum[8], word_sum}, 1'b1, 1'b0);
         packet_open = 1'b0;
         word_sum    = '0;
      end
   endtask

   task automatic predict_packet_words(input req_type r);
      if (r.start_req) begin
         if (depth_setting != DEPTH_OK || r.did_code == 8'd0 || r.sdid_code == 8'd0 ||
             r.byte_count == 8'd0) begin
            packet_open = 1'b0;
            bytes_due   = '0;
            word_sum    = '0;
            queue_word(ERROR_WORD, 1'b1, 1'b1);
         end else begin
            packet_open = 1'b1;
            bytes_due   = r.byte_count;
            word_sum    = '0;
            queue_word(ADF_ZERO, 1'b0, 1'b0);
            queue_word(ADF_ONES, 1'b0, 1'b0);
            queue_word(ADF_ONES, 1'b0, 1'b0);
            queue_coded(r.did_code);
            queue_coded(r.sdid_code);
            queue_coded(r.byte_count);
            queue_data(r.data_byte);
         end
      end else if (!packet_open) begin
         queue_word(ERROR_WORD, 1'b1, 1'b1);
      end else begin
         queue_data(r.data_byte);
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         depth_setting = DEPTH_OK;
         packet_open   = 1'b0;
         bytes_due     = '0;
         word_sum      = '0;
         due_words.delete();
      end else begin
         if (csr_wr_en)
            depth_setting = csr_wr_data;
         if (req_valid && req_ready)
            predict_packet_words(req_payload);
         if (rsp_valid && rsp_ready) begin
            if (due_words.size() == 0) begin
               report_mismatch("word with none due", rsp_payload.word, 0);
            end else begin
               want = due_words.pop_front();
               if (rsp_payload.word !== want.word)
                  report_mismatch("word", rsp_payload.word, want.word);
               if (rsp_payload.last_word !== want.last_word)
                  report_mismatch("last_word", rsp_payload.last_word, want.last_word);
               if (rsp_payload.error !== want.error)
                  report_mismatch("error", rsp_payload.error, want.error);
            end
         end
      end
      words_due = due_words.size();
   end

endmodule

FILE: bench/anc_packet_formatter_unit_tb.sv
// ---------------------------------------------------------------------------
// anc_packet_formatter_unit_tb - ancillary packet formatter testbench
// Drives start and data requests into the formatter under random sender
// gaps and receiver stalls, steps word_depth through accepted and rejected
// settings, and lets the word checker judge every packet word.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module anc_packet_formatter_unit_tb;
   import apf_pkg::*;

   localparam int PAD_CYCLES  = 10;       // quiet tail after the last words drain
   localparam int DRAIN_LIMIT = 20000;    // cycles allowed for the last words
   localparam int PHASE_ITEMS = 45;       // random requests per idling phase

   // noise requests that should be rejected or land outside a packet
   typedef enum {STRAY_DATA, ZERO_DID, ZERO_SDID, ZERO_COUNT} noise_kind_type;

   logic       clock;
   logic       reset;
   logic       csr_wr_en;
   logic [4:0] csr_wr_data;
   logic       req_valid;
   logic       req_ready;
   req_type    req_payload;
   logic       rsp_valid;
   logic       rsp_ready;
   rsp_type    rsp_payload;

   int mismatches;
   int words_due;
   int send_idle_pct;
   int recv_idle_pct;
   int requests_sent;

   anc_packet_formatter_unit dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   anc_packet_word_checker word_checker (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .mismatches  (mismatches),
      .words_due   (words_due)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // receiver stalls at the rate set for the current phase
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // hard stop well beyond the slowest correct run
   initial begin
      #2_000_000;
      $display("TB_ERROR");
      $finish;
   end

   function automatic req_type make_req(input logic start, input logic [7:0] did,
                                        input logic [7:0] sdid, input logic [7:0] cnt,
                                        input logic [7:0] data);
      req_type r;
      r.start_req  = start;
      r.did_code   = did;
      r.sdid_code  = sdid;
      r.byte_count = cnt;
      r.data_byte  = data;
      return r;
   endfunction

   // one request: optional sender gap, then hold valid until it is taken.
   // the handshake is judged from mid-cycle values so it does not race the
   // clock edge; valid is left high on return so back-to-back requests
   // never see it dropped and raised in one step
   task automatic send_request(input req_type r);
      logic fire;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      do begin
         @(negedge clock);
         fire = req_valid && req_ready;
         @(posedge clock);
      end while (!fire);
      requests_sent++;
   endtask

   // word_depth may change only once every due word has come out
   task automatic set_depth(input logic [4:0] depth);
      req_valid <= 1'b0;
      do
         @(negedge clock);
      while (words_due != 0);
      repeat (4) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= depth;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // well-formed packet with random content, now and then cut short
   task automatic send_random_packet();
      logic [7:0] did;
      logic [7:0] sdid;
      logic [7:0] cnt;
      int         items;
      did  = 8'($urandom_range(255, 1));
      sdid = 8'($urandom_range(255, 1));
      if ($urandom_range(99) < 85)
         cnt = 8'($urandom_range(6, 1));
      else
         cnt = 8'($urandom_range(40, 7));
      items = ($urandom_range(9) == 0) ? $urandom_range(cnt, 1) : cnt;
      send_request(make_req(1'b1, did, sdid, cnt, 8'($urandom)));
      // header fields on data requests are don't-care, so fill them with junk
      for (int i = 1; i < items; i++)
         send_request(make_req(1'b0, 8'($urandom), 8'($urandom), 8'($urandom),
                               8'($urandom)));
   endtask

   task automatic send_noise();
      noise_kind_type kind;
      req_type        r;
      kind = noise_kind_type'($urandom_range(3));
      r    = make_req(1'b1, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      case (kind)
         STRAY_DATA: r.start_req  = 1'b0;
         ZERO_DID:   r.did_code   = 8'd0;
         ZERO_SDID:  r.sdid_code  = 8'd0;
         default:    r.byte_count = 8'd0;
      endcase
      send_request(r);
   endtask

   task automatic run_random_phase(input int send_pct, input int recv_pct);
      int target;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      target        = requests_sent + PHASE_ITEMS;
      while (requests_sent < target) begin
         if ($urandom_range(99) < 85)
            send_random_packet();
         else
            send_noise();
      end
   endtask

   initial begin
      int drain_cycles;
      send_idle_pct = 25;
      recv_idle_pct = 87;
      requests_sent = 0;
      reset       <= 1'b1;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= '0;
      req_valid   <= 1'b0;
      req_payload <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_depth(DEPTH_OK);

      // data with no open packet, all-zero and all-one fields
      send_request(make_req(1'b0, 8'h00, 8'h00, 8'h00, 8'h00));
      send_request(make_req(1'b0, 8'hff, 8'hff, 8'hff, 8'hff));
      // rejected starts: zero did, zero sdid, zero count
      send_request(make_req(1'b1, 8'h00, 8'h05, 8'h03, 8'h12));
      send_request(make_req(1'b1, 8'h07, 8'h00, 8'h03, 8'h34));
      send_request(make_req(1'b1, 8'h07, 8'h08, 8'h00, 8'h56));
      // single-byte packets: whole packet out of one start request
      send_request(make_req(1'b1, 8'hff, 8'hff, 8'h01, 8'hff));
      send_request(make_req(1'b1, 8'h01, 8'h01, 8'h01, 8'h00));
      // short packet run to its checksum
      send_request(make_req(1'b1, 8'h41, 8'h05, 8'h03, 8'haa));
      send_request(make_req(1'b0, 8'h00, 8'h00, 8'h00, 8'h55));
      send_request(make_req(1'b0, 8'h00, 8'h00, 8'h00, 8'h80));
      // full count, abandoned after a few bytes by a new start
      send_request(make_req(1'b1, 8'h60, 8'h60, 8'hff, 8'h01));
      send_request(make_req(1'b0, 8'h00, 8'h00, 8'h00, 8'h7f));
      send_request(make_req(1'b0, 8'h00, 8'h00, 8'h00, 8'hfe));
      send_request(make_req(1'b1, 8'h45, 8'h04, 8'h02, 8'h10));
      send_request(make_req(1'b0, 8'h00, 8'h00, 8'h00, 8'h20));
      // open packet closed by a rejected start, then a stray data byte
      send_request(make_req(1'b1, 8'h45, 8'h04, 8'h04, 8'h31));
      send_request(make_req(1'b0, 8'h00, 8'h00, 8'h00, 8'h32));
      send_request(make_req(1'b1, 8'h45, 8'h00, 8'h04, 8'h33));
      send_request(make_req(1'b0, 8'h00, 8'h00, 8'h00, 8'h34));

      // leave a packet open across a word_depth change: data still flows,
      // but any start is refused while the depth is not 10
      send_request(make_req(1'b1, 8'h61, 8'h02, 8'h04, 8'h01));
      send_request(make_req(1'b0, 8'h00, 8'h00, 8'h00, 8'h02));
      set_depth(5'd0);
      send_request(make_req(1'b0, 8'h00, 8'h00, 8'h00, 8'h03));
      send_request(make_req(1'b1, 8'h61, 8'h02, 8'h04, 8'h04));
      send_request(make_req(1'b0, 8'h00, 8'h00, 8'h00, 8'h05));
      set_depth(5'd31);
      send_request(make_req(1'b1, 8'h62, 8'h03, 8'h01, 8'h06));
      send_request(make_req(1'b0, 8'h00, 8'h00, 8'h00, 8'h07));
      set_depth(DEPTH_OK);

      // random traffic: slow receiver, then slow sender, then full rate
      run_random_phase(25, 87);
      run_random_phase(87, 25);
      run_random_phase(0, 0);

      // let the last words drain, then a short quiet tail
      req_valid <= 1'b0;
      drain_cycles = 0;
      do begin
         @(negedge clock);
         drain_cycles++;
      end while (words_due != 0 && drain_cycles < DRAIN_LIMIT);
      repeat (PAD_CYCLES) @(negedge clock);

      if (mismatches == 0 && words_due == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

FILE: sim.f
src/apf_pkg.sv
src/apf_formatter.sv
src/apf_burst_buffer.sv
src/anc_packet_formatter_unit.sv
bench/anc_packet_word_checker.sv
bench/anc_packet_formatter_unit_tb.sv
